@@ rtl/stn_pkg.sv @@
// Shared constants, register codes and pipeline control type of the 3x3 mean stencil.
`timescale 1ns / 1ps
`default_nettype none

package stn_pkg;

   // Lane count of one request (fixed by the port list).
   localparam int LANES          = 5;
   localparam int WIN_W          = LANES + 1;

   localparam int DEF_MAX_GROUPS = 62;
   localparam int DEF_PIXEL_BITS = 16;

   // Configuration register widths, limits and reset values.
   localparam int GPR_W          = 6;
   localparam int RPF_W          = 12;
   localparam int MIN_GROUPS     = 2;
   localparam int MIN_ROWS       = 3;
   localparam int GPR_RESET      = 62;
   localparam int RPF_RESET      = 64;

   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUPS_PER_ROW = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_PER_FRAME = CSR_INDEX_W'(1);

   // Mean = (sum9 * 7282 + 2^15) >> 16, 7282 ~ 2^16 / 9.
   localparam int MUL_W          = 13;
   localparam int MEAN_MUL       = 7282;
   localparam int MEAN_SHIFT     = 16;
   localparam int MEAN_HALF      = 32768;

   // Result queue depth (power of two).
   localparam int OUT_DEPTH      = 8;

   // Control word that travels with each pipeline slot.
   typedef struct packed {
      logic valid;      // slot holds a request or a flush read
      logic is_flush;   // halo read of the frame's last row
      logic top_sel;    // line store bank holding the top row
      logic emit1;      // result for group c-1
      logic emit2;      // result for group c (row end)
      logic halo_row;   // output row is the first row
      logic left1;      // first result is group 0
      logic left2;      // second result is group 0
      logic run_last1;  // first result closes the request
      logic run_last2;  // second result closes the request
      logic flush_end;  // last flush read of the frame
   } stn_ctl_type;

endpackage

`default_nettype wire

@@ rtl/stn_line_store.sv @@
// One bank of the line store: synchronous RAM, read-first, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module stn_line_store
   import stn_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_GROUPS,
   parameter int WIDTH = LANES * DEF_PIXEL_BITS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/stn_window.sv @@
// Window registers and nine-sample sums for both candidate results of a slot.
`timescale 1ns / 1ps
`default_nettype none

module stn_window
   import stn_pkg::*;
#(
   parameter int PIXEL_BITS = DEF_PIXEL_BITS,
   localparam int SUM_W = PIXEL_BITS + 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire stn_ctl_type                       s1_ctl,
   input  wire logic [LANES-1:0][PIXEL_BITS-1:0]  s1_pix,
   input  wire logic [LANES-1:0][PIXEL_BITS-1:0]  bank0_rd,
   input  wire logic [LANES-1:0][PIXEL_BITS-1:0]  bank1_rd,
   output stn_ctl_type                            s2_ctl_ff,
   output logic      [LANES-1:0][SUM_W-1:0]       sum1_ff,
   output logic      [LANES-1:0][SUM_W-1:0]       sum2_ff,
   output logic      [LANES-1:0][PIXEL_BITS-1:0]  ctr1_ff,
   output logic      [LANES-1:0][PIXEL_BITS-1:0]  ctr2_ff
);

   localparam int COL_W = PIXEL_BITS + 2;

   logic [PIXEL_BITS-1:0] win_ff [3][WIN_W];
   logic [PIXEL_BITS-1:0] cur    [3][LANES];
   logic [PIXEL_BITS-1:0] a1     [3][WIN_W+1];
   logic [PIXEL_BITS-1:0] a2     [3][WIN_W+1];
   logic [COL_W-1:0]      col1   [WIN_W+1];
   logic [COL_W-1:0]      col2   [WIN_W+1];
   logic [LANES-1:0][SUM_W-1:0]      sum1_in, sum2_in;
   logic [LANES-1:0][PIXEL_BITS-1:0] ctr1_in, ctr2_in;

   // rows: 0 = top (r-2), 1 = middle (r-1), 2 = incoming (r)
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         cur[0][k] = s1_ctl.top_sel ? bank1_rd[k] : bank0_rd[k];
         cur[1][k] = s1_ctl.top_sel ? bank0_rd[k] : bank1_rd[k];
         cur[2][k] = s1_pix[k];
      end
   end

   // a1: window before this request plus right neighbor; a2: window after it
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < WIN_W; j++) begin
            a1[i][j] = win_ff[i][j];
         end
         a1[i][WIN_W] = cur[i][0];
         a2[i][0]     = win_ff[i][LANES];
         for (int k = 0; k < LANES; k++) begin
            a2[i][k+1] = cur[i][k];
         end
         a2[i][WIN_W] = '0;
      end
   end

   always_comb begin
      for (int j = 0; j <= WIN_W; j++) begin
         col1[j] = COL_W'(a1[0][j]) + COL_W'(a1[1][j]) + COL_W'(a1[2][j]);
         col2[j] = COL_W'(a2[0][j]) + COL_W'(a2[1][j]) + COL_W'(a2[2][j]);
      end
      for (int k = 0; k < LANES; k++) begin
         sum1_in[k] = SUM_W'(col1[k]) + SUM_W'(col1[k+1]) + SUM_W'(col1[k+2]);
         sum2_in[k] = SUM_W'(col2[k]) + SUM_W'(col2[k+1]) + SUM_W'(col2[k+2]);
         // a flush slot carries the top bank data as its halo values
         ctr1_in[k] = s1_ctl.is_flush ? cur[0][k] : a1[1][k+1];
         ctr2_in[k] = a2[1][k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < WIN_W; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         s2_ctl_ff <= s1_ctl;
         if (s1_ctl.valid && !s1_ctl.is_flush) begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < WIN_W; j++) begin
                  win_ff[i][j] <= a2[i][j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sum1_ff <= sum1_in;
      sum2_ff <= sum2_in;
      ctr1_ff <= ctr1_in;
      ctr2_ff <= ctr2_in;
   end

endmodule

`default_nettype wire

@@ rtl/stn_mean.sv @@
// Reciprocal multiply, rounding, saturation and halo selection; forms queue entries.
`timescale 1ns / 1ps
`default_nettype none

module stn_mean
   import stn_pkg::*;
#(
   parameter int PIXEL_BITS = DEF_PIXEL_BITS,
   localparam int SUM_W   = PIXEL_BITS + 4,
   localparam int ENTRY_W = LANES * PIXEL_BITS + 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire stn_ctl_type                       s2_ctl,
   input  wire logic [LANES-1:0][SUM_W-1:0]       sum1,
   input  wire logic [LANES-1:0][SUM_W-1:0]       sum2,
   input  wire logic [LANES-1:0][PIXEL_BITS-1:0]  ctr1,
   input  wire logic [LANES-1:0][PIXEL_BITS-1:0]  ctr2,
   output logic      [1:0]                        push_cnt,
   output logic      [ENTRY_W-1:0]                push_e0,
   output logic      [ENTRY_W-1:0]                push_e1
);

   localparam int PROD_W = SUM_W + MUL_W;
   localparam logic [PROD_W:0] PIX_MAX = (PROD_W+1)'((65'd1 << PIXEL_BITS) - 65'd1);

   stn_ctl_type                       s3_ctl_ff;
   logic [LANES-1:0][PROD_W-1:0]      prod1_ff, prod2_ff;
   logic [LANES-1:0][PIXEL_BITS-1:0]  c1_ff, c2_ff;
   logic [LANES-1:0][PIXEL_BITS-1:0]  res1, res2;
   logic [ENTRY_W-1:0]                ent1, ent2, ent_fl;

   function automatic logic [PIXEL_BITS-1:0] round_sat(input logic [PROD_W-1:0] p);
      logic [PROD_W:0] rnd;
      rnd = ({1'b0, p} + (PROD_W+1)'(MEAN_HALF)) >> MEAN_SHIFT;
      if (rnd > PIX_MAX) begin
         return PIX_MAX[PIXEL_BITS-1:0];
      end
      return rnd[PIXEL_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s2_ctl;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         prod1_ff[k] <= PROD_W'(sum1[k]) * PROD_W'(MEAN_MUL);
         prod2_ff[k] <= PROD_W'(sum2[k]) * PROD_W'(MEAN_MUL);
      end
      c1_ff <= ctr1;
      c2_ff <= ctr2;
   end

   // first row, leftmost lane of group 0 and rightmost lane of the last group pass through
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (s3_ctl_ff.halo_row || (s3_ctl_ff.left1 && k == 0)) begin
            res1[k] = c1_ff[k];
         end else begin
            res1[k] = round_sat(prod1_ff[k]);
         end
         if (s3_ctl_ff.halo_row || (s3_ctl_ff.left2 && k == 0) || k == LANES - 1) begin
            res2[k] = c2_ff[k];
         end else begin
            res2[k] = round_sat(prod2_ff[k]);
         end
      end
   end

   assign ent1   = {1'b0, s3_ctl_ff.run_last1, res1};
   assign ent2   = {1'b0, s3_ctl_ff.run_last2, res2};
   assign ent_fl = {s3_ctl_ff.flush_end, s3_ctl_ff.flush_end, c1_ff};

   always_comb begin
      push_e0 = ent1;
      push_e1 = ent2;
      if (!s3_ctl_ff.valid) begin
         push_cnt = 2'd0;
      end else if (s3_ctl_ff.is_flush) begin
         push_cnt = 2'd1;
         push_e0  = ent_fl;
      end else begin
         push_cnt = {1'b0, s3_ctl_ff.emit1} + {1'b0, s3_ctl_ff.emit2};
         if (!s3_ctl_ff.emit1) begin
            push_e0 = ent2;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/stn_out_queue.sv @@
// Result queue: takes up to two entries a cycle, hands one a cycle to the response port when popped.
`timescale 1ns / 1ps
`default_nettype none

module stn_out_queue
   import stn_pkg::*;
#(
   parameter int WIDTH = LANES * DEF_PIXEL_BITS + 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       push_cnt,
   input  wire logic [WIDTH-1:0] push_e0,
   input  wire logic [WIDTH-1:0] push_e1,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic      [WIDTH-1:0] head_entry
);

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   logic [WIDTH-1:0] q_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign head_valid = (count_ff != '0);
   assign head_entry = q_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         q_ff[wr_ptr_ff] <= push_e0;
      end
      if (push_cnt == 2'd2) begin
         q_ff[wr_ptr_ff + PTR_W'(1)] <= push_e1;
      end
   end

endmodule

`default_nettype wire

@@ rtl/stencil_3x3_mean_five_lane_top.sv @@
// Top level of the five-lane 3x3 mean stencil: sequencing, line store, pipeline and ports.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  req     | in  | req_valid/req_stall  | req_pix0..req_pix4 (one five-pixel group)
//  rsp     | out | rsp_valid/rsp_stall  | rsp_res0..rsp_res4, rsp_run_end, rsp_frame_end
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_wdata (ready is always high)
//
// One request per cycle unless req_stall; results pass s1, window, product and queue regs.
// The line store (two read-first RAM banks, one per stored row) is read at the group's
// column and overwritten in the same cycle, so requests never wait on it.
// A row end gives two results; credits for queued and in-flight results on the eight-entry
// result queue hold req_stall while results back up. After the frame's last request, req
// stalls while the last row is read back as halo, group by group.
// Reset is synchronous; it clears control, window and queue; no RAM clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stencil_3x3_mean_five_lane_top
   import stn_pkg::*;
#(
   parameter int MAX_GROUPS = DEF_MAX_GROUPS,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [PIXEL_BITS-1:0]  req_pix0,
   input  wire logic [PIXEL_BITS-1:0]  req_pix1,
   input  wire logic [PIXEL_BITS-1:0]  req_pix2,
   input  wire logic [PIXEL_BITS-1:0]  req_pix3,
   input  wire logic [PIXEL_BITS-1:0]  req_pix4,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [PIXEL_BITS-1:0]  rsp_res0,
   output logic      [PIXEL_BITS-1:0]  rsp_res1,
   output logic      [PIXEL_BITS-1:0]  rsp_res2,
   output logic      [PIXEL_BITS-1:0]  rsp_res3,
   output logic      [PIXEL_BITS-1:0]  rsp_res4,
   output logic                        rsp_run_end,
   output logic                        rsp_frame_end,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int ROW_W   = LANES * PIXEL_BITS;
   localparam int ENTRY_W = ROW_W + 2;
   localparam int SUM_W   = PIXEL_BITS + 4;
   localparam int RSV_W   = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   // configuration
   logic [GPR_W-1:0] gpr_ff;
   logic [RPF_W-1:0] rpf_ff;

   // frame position
   logic [GPR_W-1:0] col_ff, col_in;
   logic [RPF_W-1:0] row_ff, row_in;
   logic [GPR_W-1:0] g_eff;
   logic [RPF_W-1:0] r_eff;
   logic             end_row, frame_last;
   logic [ADDR_W-1:0] col_addr;

   // halo flush sequencer
   state_type        state_ff, state_in;
   logic [ADDR_W-1:0] flush_g_ff, flush_g_in, flush_last_ff, flush_last_in;
   logic             flush_bank_ff, flush_bank_in;

   // result credits: queue entries plus results still in the pipeline
   logic [RSV_W-1:0] reserved_ff, reserved_in;
   logic             credit_ok;
   logic [1:0]       issue_cnt;

   logic             req_acc, flush_issue, rsp_pop;
   stn_ctl_type      issue_ctl, s1_ctl_ff, s2_ctl;
   logic [LANES-1:0][PIXEL_BITS-1:0] req_group, s1_pix_ff;
   logic [LANES-1:0][PIXEL_BITS-1:0] bank0_rd, bank1_rd;
   logic [ADDR_W-1:0] rd_addr;

   logic [LANES-1:0][SUM_W-1:0]      sum1, sum2;
   logic [LANES-1:0][PIXEL_BITS-1:0] ctr1, ctr2;
   logic [1:0]                       push_cnt;
   logic [ENTRY_W-1:0]               push_e0, push_e1, head_entry;
   logic [LANES-1:0][PIXEL_BITS-1:0] head_res;

   assign req_group = {req_pix4, req_pix3, req_pix2, req_pix1, req_pix0};

   // ---------------------------------------------------------------- config port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_ff <= GPR_W'(GPR_RESET);
         rpf_ff <= RPF_W'(RPF_RESET);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GROUPS_PER_ROW: gpr_ff <= csr_wdata[GPR_W-1:0];
            CSR_ROWS_PER_FRAME: rpf_ff <= csr_wdata[RPF_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- position
   // Register values are clamped to the legal frame shape before use.
   always_comb begin
      if (gpr_ff < GPR_W'(MIN_GROUPS)) begin
         g_eff = GPR_W'(MIN_GROUPS);
      end else if (gpr_ff > GPR_W'(MAX_GROUPS)) begin
         g_eff = GPR_W'(MAX_GROUPS);
      end else begin
         g_eff = gpr_ff;
      end
      if (rpf_ff < RPF_W'(MIN_ROWS)) begin
         r_eff = RPF_W'(MIN_ROWS);
      end else begin
         r_eff = rpf_ff;
      end
   end

   assign end_row    = (col_ff >= g_eff - GPR_W'(1));
   assign frame_last = end_row && (row_ff >= r_eff - RPF_W'(1));
   assign col_addr   = (col_ff > GPR_W'(MAX_GROUPS - 1)) ? ADDR_W'(MAX_GROUPS - 1)
                                                         : col_ff[ADDR_W-1:0];

   // ---------------------------------------------------------------- issue
   assign credit_ok   = (reserved_ff <= RSV_W'(OUT_DEPTH - 2));
   assign req_stall   = (state_ff != ST_RUN) || !credit_ok;
   assign req_acc     = req_valid && !req_stall;
   assign flush_issue = (state_ff == ST_FLUSH) && credit_ok;
   assign rsp_pop     = rsp_valid && !rsp_stall;
   assign rd_addr     = flush_issue ? flush_g_ff : col_addr;

   always_comb begin
      issue_ctl = '0;
      issue_cnt = 2'd0;
      if (req_acc) begin
         issue_ctl.valid     = 1'b1;
         issue_ctl.top_sel   = row_ff[0];
         issue_ctl.emit1     = (row_ff != '0) && (col_ff != '0);
         issue_ctl.emit2     = end_row && (row_ff != '0);
         issue_ctl.halo_row  = (row_ff == RPF_W'(1));
         issue_ctl.left1     = (col_ff == GPR_W'(1));
         issue_ctl.left2     = (col_ff == '0);
         issue_ctl.run_last1 = issue_ctl.emit1 && !issue_ctl.emit2 && !frame_last;
         issue_ctl.run_last2 = issue_ctl.emit2 && !frame_last;
         issue_cnt = {1'b0, issue_ctl.emit1} + {1'b0, issue_ctl.emit2};
      end else if (flush_issue) begin
         issue_ctl.valid     = 1'b1;
         issue_ctl.is_flush  = 1'b1;
         issue_ctl.top_sel   = flush_bank_ff;
         issue_ctl.flush_end = (flush_g_ff == flush_last_ff);
         issue_cnt = 2'd1;
      end
   end

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      state_in      = state_ff;
      flush_g_in    = flush_g_ff;
      flush_last_in = flush_last_ff;
      flush_bank_in = flush_bank_ff;
      case (state_ff)
         ST_RUN: begin
            if (req_acc) begin
               if (frame_last) begin
                  // read the last row back out as halo, groups 0..c
                  col_in        = '0;
                  row_in        = '0;
                  state_in      = ST_FLUSH;
                  flush_g_in    = '0;
                  flush_last_in = col_addr;
                  flush_bank_in = row_ff[0];
               end else if (end_row) begin
                  col_in = '0;
                  row_in = row_ff + RPF_W'(1);
               end else begin
                  col_in = col_ff + GPR_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (flush_issue) begin
               if (flush_g_ff == flush_last_ff) begin
                  state_in = ST_RUN;
               end else begin
                  flush_g_in = flush_g_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign reserved_in = reserved_ff + RSV_W'(issue_cnt) - RSV_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         state_ff      <= ST_RUN;
         flush_g_ff    <= '0;
         flush_last_ff <= '0;
         flush_bank_ff <= 1'b0;
         reserved_ff   <= '0;
         s1_ctl_ff     <= '0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         state_ff      <= state_in;
         flush_g_ff    <= flush_g_in;
         flush_last_ff <= flush_last_in;
         flush_bank_ff <= flush_bank_in;
         reserved_ff   <= reserved_in;
         s1_ctl_ff     <= issue_ctl;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff <= req_group;
   end

   // ---------------------------------------------------------------- line store
   // Bank r&1 holds row r-2 on read and takes row r on write, same address.
   stn_line_store #(
      .DEPTH (MAX_GROUPS),
      .WIDTH (ROW_W)
   ) u_bank0 (
      .clock      (clock),
      .wr_en      (req_acc && !row_ff[0]),
      .wr_addr    (col_addr),
      .wr_data    (req_group),
      .rd_addr    (rd_addr),
      .rd_data_ff (bank0_rd)
   );

   stn_line_store #(
      .DEPTH (MAX_GROUPS),
      .WIDTH (ROW_W)
   ) u_bank1 (
      .clock      (clock),
      .wr_en      (req_acc && row_ff[0]),
      .wr_addr    (col_addr),
      .wr_data    (req_group),
      .rd_addr    (rd_addr),
      .rd_data_ff (bank1_rd)
   );

   // ---------------------------------------------------------------- datapath
   stn_window #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .s1_ctl    (s1_ctl_ff),
      .s1_pix    (s1_pix_ff),
      .bank0_rd  (bank0_rd),
      .bank1_rd  (bank1_rd),
      .s2_ctl_ff (s2_ctl),
      .sum1_ff   (sum1),
      .sum2_ff   (sum2),
      .ctr1_ff   (ctr1),
      .ctr2_ff   (ctr2)
   );

   stn_mean #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_mean (
      .clock    (clock),
      .reset    (reset),
      .s2_ctl   (s2_ctl),
      .sum1     (sum1),
      .sum2     (sum2),
      .ctr1     (ctr1),
      .ctr2     (ctr2),
      .push_cnt (push_cnt),
      .push_e0  (push_e0),
      .push_e1  (push_e1)
   );

   stn_out_queue #(
      .WIDTH (ENTRY_W)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_e0    (push_e0),
      .push_e1    (push_e1),
      .pop        (rsp_pop),
      .head_valid (rsp_valid),
      .head_entry (head_entry)
   );

   assign {rsp_frame_end, rsp_run_end, head_res} = head_entry;
   assign rsp_res0 = head_res[0];
   assign rsp_res1 = head_res[1];
   assign rsp_res2 = head_res[2];
   assign rsp_res3 = head_res[3];
   assign rsp_res4 = head_res[4];

endmodule

`default_nettype wire

@@ rtl/stn_checker.sv @@
// Port-level checker for the stencil top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module stn_checker
   import stn_pkg::*;
#(
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [PIXEL_BITS-1:0] rsp_res0,
   input wire logic [PIXEL_BITS-1:0] rsp_res1,
   input wire logic [PIXEL_BITS-1:0] rsp_res2,
   input wire logic [PIXEL_BITS-1:0] rsp_res3,
   input wire logic [PIXEL_BITS-1:0] rsp_res4,
   input wire logic                  rsp_run_end,
   input wire logic                  rsp_frame_end
);

   // set once any request has been taken since reset
   logic seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         seen_ff <= 1'b1;
      end
   end

   // no result is left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // results only follow requests
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_ff)
      else $error("response without any request");

   // the frame's last result also closes its request
   a_frame_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_end)
      else $error("frame end without run end");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res0) && $stable(rsp_res1)
         && $stable(rsp_res2) && $stable(rsp_res3) && $stable(rsp_res4)
         && $stable(rsp_run_end) && $stable(rsp_frame_end))
      else $error("stalled response changed");

endmodule

bind stencil_3x3_mean_five_lane_top stn_checker #(.PIXEL_BITS(PIXEL_BITS)) u_checker (.*);

`default_nettype wire
